/* rtl/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants for the Catmull-Rom spline evaluator
// Widths, word layouts, status codes and the fixed-point helpers used by the
// axis lanes and the output stage.
// ----------------------------------------------------------------------------
package ccr_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_W    = 32;
   localparam int T_FRAC     = 16;
   localparam int T_W        = T_FRAC + 1;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 7;
   localparam int AXES       = 3;
   localparam int WIN        = 4;
   localparam int BANKS      = 4;
   localparam int SEL_W      = $clog2(BANKS);
   localparam int BANK_DEPTH = MAX_POINTS / BANKS;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int SUM_W      = COORD_W + 6;
   localparam int PROD_W     = SUM_W + T_W;
   localparam int NSTAGE     = 8;
   localparam int STS_W      = 2;

   // request word layout, lowest bits first
   localparam int IDX_LSB    = 0;
   localparam int X_LSB      = IDX_LSB + IDX_W;
   localparam int Y_LSB      = X_LSB + COORD_W;
   localparam int Z_LSB      = Y_LSB + COORD_W;
   localparam int T_LSB      = Z_LSB + COORD_W;
   localparam int REQ_BITS   = T_LSB + T_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((AXES * COORD_W + 7) / 8) * 8;

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [AXES-1:0]      point_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [PROD_W-1:0]         prod_type;

   localparam sum_type COORD_MAX_S = sum_type'({1'b0, {(COORD_W-1){1'b1}}});
   localparam sum_type COORD_MIN_S = -COORD_MAX_S - sum_type'(1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_CLAMP_HIGH = 2'd1,
      STATUS_CLAMP_LOW  = 2'd2,
      STATUS_FEW        = 2'd3
   } status_type;

   typedef struct packed {
      logic coef;
      logic mul1;
      logic add1;
      logic mul2;
      logic add2;
      logic mul3;
      logic add3;
   } lane_en_type;

   // product / 2^T_FRAC, round to nearest with ties away from zero, sign restored
   function automatic sum_type round_mul(input prod_type prod, input logic neg);
      prod_type q;
      q = (prod + (PROD_W'(1) << (T_FRAC - 1))) >> T_FRAC;
      return neg ? -sum_type'(q[SUM_W-1:0]) : sum_type'(q[SUM_W-1:0]);
   endfunction

   // halve with ties away from zero, then clip to the coordinate range
   function automatic coord_type halve_sat(input sum_type s);
      logic             neg;
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] half;
      sum_type          r;
      neg  = s[SUM_W-1];
      mag  = neg ? SUM_W'(-s) : SUM_W'(s);
      half = (mag + SUM_W'(1)) >> 1;
      r    = neg ? -sum_type'(half) : sum_type'(half);
      if (r > COORD_MAX_S) begin
         r = COORD_MAX_S;
      end else if (r < COORD_MIN_S) begin
         r = COORD_MIN_S;
      end
      return coord_type'(r[COORD_W-1:0]);
   endfunction

endpackage

/* rtl/ccr_point_store.sv */
// ----------------------------------------------------------------------------
// ccr_point_store: banked control point table
// Four banks interleaved on the low index bits, so any four consecutive
// points sit in distinct banks and are read together in the same cycle.
// ----------------------------------------------------------------------------
module ccr_point_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ccr_pkg::IDX_W-1:0]  wr_index,
   input  ccr_pkg::point_type         wr_point,
   input  logic                       rd_en,
   input  logic [ccr_pkg::IDX_W-1:0]  rd_base,
   output ccr_pkg::point_type         win [ccr_pkg::WIN]
);

   ccr_pkg::point_type              bank_q [ccr_pkg::BANKS];
   logic [ccr_pkg::SEL_W-1:0]       rot_ff;
   logic [ccr_pkg::SEL_W-1:0]       rot_in;

   assign rot_in = rd_base[ccr_pkg::SEL_W-1:0];

   for (genvar b = 0; b < ccr_pkg::BANKS; b++) begin : g_bank
      ccr_pkg::point_type             mem [ccr_pkg::BANK_DEPTH];
      logic [ccr_pkg::SEL_W-1:0]      ofs;
      logic [ccr_pkg::IDX_W-1:0]      rd_idx;
      logic [ccr_pkg::BANK_AW-1:0]    rd_addr;

      assign ofs     = ccr_pkg::SEL_W'(b) - rot_in;
      assign rd_idx  = rd_base + ccr_pkg::IDX_W'(ofs);
      assign rd_addr = rd_idx[ccr_pkg::IDX_W-1:ccr_pkg::SEL_W];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_index[ccr_pkg::SEL_W-1:0] == ccr_pkg::SEL_W'(b))) begin
            mem[wr_index[ccr_pkg::IDX_W-1:ccr_pkg::SEL_W]] <= wr_point;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            bank_q[b] <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rot_ff <= rot_in;
      end
   end

   // undo the bank rotation: window slot k is point rd_base + k
   always_comb begin
      for (int k = 0; k < ccr_pkg::WIN; k++) begin
         win[k] = bank_q[rot_ff + ccr_pkg::SEL_W'(k)];
      end
   end

endmodule

/* rtl/ccr_lane.sv */
// ----------------------------------------------------------------------------
// ccr_lane: one axis of the spline polynomial
// Coefficient stage followed by three Horner steps, each split into a
// multiply stage and a round-and-add stage.
// ----------------------------------------------------------------------------
module ccr_lane (
   input  logic                     clock,
   input  ccr_pkg::lane_en_type     en,
   input  logic [ccr_pkg::T_W-1:0]  t_param,
   input  ccr_pkg::coord_type       p0,
   input  ccr_pkg::coord_type       p1,
   input  ccr_pkg::coord_type       p2,
   input  ccr_pkg::coord_type       p3,
   output ccr_pkg::sum_type         sum
);

   ccr_pkg::sum_type e0, e1, e2, e3;
   ccr_pkg::sum_type a_in, b_in, c_in, d_in;

   // coefficient stage
   ccr_pkg::sum_type          a1_ff, b1_ff, c1_ff, d1_ff;
   logic [ccr_pkg::T_W-1:0]   t1_ff;
   // first Horner step
   ccr_pkg::prod_type         pr2_ff;
   logic                      ng2_ff;
   ccr_pkg::sum_type          a2_ff, b2_ff, c2_ff;
   logic [ccr_pkg::T_W-1:0]   t2_ff;
   ccr_pkg::sum_type          s3_ff, a3_ff, b3_ff;
   logic [ccr_pkg::T_W-1:0]   t3_ff;
   // second Horner step
   ccr_pkg::prod_type         pr4_ff;
   logic                      ng4_ff;
   ccr_pkg::sum_type          a4_ff, b4_ff;
   logic [ccr_pkg::T_W-1:0]   t4_ff;
   ccr_pkg::sum_type          s5_ff, a5_ff;
   logic [ccr_pkg::T_W-1:0]   t5_ff;
   // third Horner step
   ccr_pkg::prod_type         pr6_ff;
   logic                      ng6_ff;
   ccr_pkg::sum_type          a6_ff;
   ccr_pkg::sum_type          s7_ff;

   logic [ccr_pkg::SUM_W-1:0] mag2_in, mag4_in, mag6_in;

   assign e0 = ccr_pkg::SUM_W'(p0);
   assign e1 = ccr_pkg::SUM_W'(p1);
   assign e2 = ccr_pkg::SUM_W'(p2);
   assign e3 = ccr_pkg::SUM_W'(p3);

   assign a_in = e1 <<< 1;
   assign b_in = e2 - e0;
   assign c_in = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
   assign d_in = ((e1 <<< 1) + e1) - e0 - ((e2 <<< 1) + e2) + e3;

   assign mag2_in = d1_ff[ccr_pkg::SUM_W-1] ? ccr_pkg::SUM_W'(-d1_ff) : ccr_pkg::SUM_W'(d1_ff);
   assign mag4_in = s3_ff[ccr_pkg::SUM_W-1] ? ccr_pkg::SUM_W'(-s3_ff) : ccr_pkg::SUM_W'(s3_ff);
   assign mag6_in = s5_ff[ccr_pkg::SUM_W-1] ? ccr_pkg::SUM_W'(-s5_ff) : ccr_pkg::SUM_W'(s5_ff);

   always_ff @(posedge clock) begin
      if (en.coef) begin
         a1_ff <= a_in;
         b1_ff <= b_in;
         c1_ff <= c_in;
         d1_ff <= d_in;
         t1_ff <= t_param;
      end
      if (en.mul1) begin
         pr2_ff <= ccr_pkg::PROD_W'(mag2_in) * ccr_pkg::PROD_W'(t1_ff);
         ng2_ff <= d1_ff[ccr_pkg::SUM_W-1];
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         t2_ff  <= t1_ff;
      end
      if (en.add1) begin
         s3_ff <= c2_ff + ccr_pkg::round_mul(pr2_ff, ng2_ff);
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         t3_ff <= t2_ff;
      end
      if (en.mul2) begin
         pr4_ff <= ccr_pkg::PROD_W'(mag4_in) * ccr_pkg::PROD_W'(t3_ff);
         ng4_ff <= s3_ff[ccr_pkg::SUM_W-1];
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         t4_ff  <= t3_ff;
      end
      if (en.add2) begin
         s5_ff <= b4_ff + ccr_pkg::round_mul(pr4_ff, ng4_ff);
         a5_ff <= a4_ff;
         t5_ff <= t4_ff;
      end
      if (en.mul3) begin
         pr6_ff <= ccr_pkg::PROD_W'(mag6_in) * ccr_pkg::PROD_W'(t5_ff);
         ng6_ff <= s5_ff[ccr_pkg::SUM_W-1];
         a6_ff  <= a5_ff;
      end
      if (en.add3) begin
         s7_ff <= a6_ff + ccr_pkg::round_mul(pr6_ff, ng6_ff);
      end
   end

   assign sum = s7_ff;

endmodule

/* rtl/ccr_merge.sv */
// ----------------------------------------------------------------------------
// ccr_merge: result assembly and output register
// Halves and clips each lane's sum, zeroes the position on a too-few-points
// status and holds the response word until it is taken.
// ----------------------------------------------------------------------------
module ccr_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  ccr_pkg::sum_type                lane_sum [ccr_pkg::AXES],
   input  ccr_pkg::status_type             status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ccr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [ccr_pkg::STS_W-1:0]       rsp_tuser
);

   logic                            vld_ff, vld_in;
   logic [ccr_pkg::RSP_DATA_W-1:0]  data_ff, data_in;
   logic [ccr_pkg::STS_W-1:0]       sts_ff;
   ccr_pkg::point_type              pos;

   always_comb begin
      for (int ax = 0; ax < ccr_pkg::AXES; ax++) begin
         pos[ax] = (status == ccr_pkg::STATUS_FEW) ? '0 : ccr_pkg::halve_sat(lane_sum[ax]);
      end
   end

   assign data_in  = ccr_pkg::RSP_DATA_W'(pos);
   assign in_ready = !vld_ff || rsp_tready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
         sts_ff  <= status;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = sts_ff;

endmodule

/* rtl/catmull_rom_spline_eval.sv */
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval: uniform Catmull-Rom segment evaluator
// Point table with banked four-point reads, three axis lanes of fixed-point
// Horner evaluation and a merging output stage.
//
//   channel  direction  word
//   req_     in         tuser: op; tdata: index, x, y, z, t
//   rsp_     out        tuser: status; tdata: x, y, z
//   csr_     in         wr_data: point_count
//
// One word per cycle on req_ while req_tready is high. A write word updates
// the table at acceptance and gives no response. An evaluate word reads four
// points at once from the banked table and passes through the table read,
// coefficient stage, three two-stage multiply-and-round steps, output register.
// Reset clears point_count and the pipeline valid bits, not the table.
// A stalled rsp_ backs up stage by stage; req_tready drops only when the
// first stage is full and cannot move.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval (
   input  logic                             clock,
   input  logic                             reset,
   // tuser: op
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
   //        t_param[118:102], zero pad
   input  logic [ccr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic [ccr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: status
   output logic [ccr_pkg::STS_W-1:0]        rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [ccr_pkg::CNT_W-1:0]        csr_wr_data
);

   logic [ccr_pkg::CNT_W-1:0]   count_ff, count_in;

   ccr_pkg::op_type             op;
   logic [ccr_pkg::IDX_W-1:0]   idx;
   logic [ccr_pkg::T_W-1:0]     t_raw;
   ccr_pkg::point_type          wr_point;
   logic                        accept, eval_acc, wr_acc;

   logic [ccr_pkg::CNT_W-1:0]   cnt, cnt_m2;
   logic [ccr_pkg::IDX_W-1:0]   seg, base;
   ccr_pkg::status_type         sts_in;
   logic [ccr_pkg::T_W-1:0]     t_in;

   logic [ccr_pkg::NSTAGE-1:0]  vld_ff, vld_in, rdy;
   ccr_pkg::status_type         sts_ff [ccr_pkg::NSTAGE];
   logic [ccr_pkg::T_W-1:0]     t_ff;
   logic                        mrg_ready;
   ccr_pkg::lane_en_type        lane_en;
   ccr_pkg::point_type          win [ccr_pkg::WIN];
   ccr_pkg::point_type          lane_win [ccr_pkg::WIN];
   ccr_pkg::sum_type            lane_sum [ccr_pkg::AXES];

   // ---- request decode
   assign op    = ccr_pkg::op_type'(req_tuser);
   assign idx   = req_tdata[ccr_pkg::IDX_LSB +: ccr_pkg::IDX_W];
   assign t_raw = req_tdata[ccr_pkg::T_LSB +: ccr_pkg::T_W];
   assign wr_point[0] = req_tdata[ccr_pkg::X_LSB +: ccr_pkg::COORD_W];
   assign wr_point[1] = req_tdata[ccr_pkg::Y_LSB +: ccr_pkg::COORD_W];
   assign wr_point[2] = req_tdata[ccr_pkg::Z_LSB +: ccr_pkg::COORD_W];

   assign req_tready = rdy[0];
   assign accept     = req_tvalid && req_tready;
   assign eval_acc   = accept && (op == ccr_pkg::OP_EVAL);
   assign wr_acc     = accept && (op == ccr_pkg::OP_WRITE);

   // ---- point count register
   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---- segment selection; a clamped segment feeds p1 to all four taps, giving p1
   assign cnt    = (count_ff > ccr_pkg::CNT_W'(ccr_pkg::MAX_POINTS)) ?
                   ccr_pkg::CNT_W'(ccr_pkg::MAX_POINTS) : count_ff;
   assign cnt_m2 = cnt - ccr_pkg::CNT_W'(2);

   always_comb begin
      sts_in = ccr_pkg::STATUS_OK;
      seg    = idx;
      if (cnt < ccr_pkg::CNT_W'(4)) begin
         sts_in = ccr_pkg::STATUS_FEW;
         seg    = ccr_pkg::IDX_W'(1);
      end else if (idx == '0) begin
         sts_in = ccr_pkg::STATUS_CLAMP_LOW;
         seg    = ccr_pkg::IDX_W'(1);
      end else if (ccr_pkg::CNT_W'(idx) >= cnt_m2) begin
         sts_in = ccr_pkg::STATUS_CLAMP_HIGH;
         seg    = cnt_m2[ccr_pkg::IDX_W-1:0];
      end
   end

   assign base = seg - ccr_pkg::IDX_W'(1);
   assign t_in = (sts_in != ccr_pkg::STATUS_OK) ? '0 :
                 (t_raw > ccr_pkg::T_ONE) ? ccr_pkg::T_ONE : t_raw;

   // ---- pipeline flow control
   always_comb begin
      rdy[ccr_pkg::NSTAGE-1] = !vld_ff[ccr_pkg::NSTAGE-1] || mrg_ready;
      for (int k = ccr_pkg::NSTAGE - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      vld_in[0] = rdy[0] ? eval_acc : vld_ff[0];
      for (int k = 1; k < ccr_pkg::NSTAGE; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sts_ff[0] <= sts_in;
         t_ff      <= t_in;
      end
      for (int k = 1; k < ccr_pkg::NSTAGE; k++) begin
         if (rdy[k]) begin
            sts_ff[k] <= sts_ff[k-1];
         end
      end
   end

   assign lane_en.coef = rdy[1];
   assign lane_en.mul1 = rdy[2];
   assign lane_en.add1 = rdy[3];
   assign lane_en.mul2 = rdy[4];
   assign lane_en.add2 = rdy[5];
   assign lane_en.mul3 = rdy[6];
   assign lane_en.add3 = rdy[7];

   // ---- datapath
   ccr_point_store u_store (
      .clock    (clock),
      .wr_en    (wr_acc),
      .wr_index (idx),
      .wr_point (wr_point),
      .rd_en    (rdy[0]),
      .rd_base  (base),
      .win      (win)
   );

   always_comb begin
      for (int k = 0; k < ccr_pkg::WIN; k++) begin
         lane_win[k] = (sts_ff[0] == ccr_pkg::STATUS_OK) ? win[k] : win[1];
      end
   end

   for (genvar ax = 0; ax < ccr_pkg::AXES; ax++) begin : g_lane
      ccr_lane u_lane (
         .clock   (clock),
         .en      (lane_en),
         .t_param (t_ff),
         .p0      (lane_win[0][ax]),
         .p1      (lane_win[1][ax]),
         .p2      (lane_win[2][ax]),
         .p3      (lane_win[3][ax]),
         .sum     (lane_sum[ax])
      );
   end

   ccr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_ff[ccr_pkg::NSTAGE-1]),
      .in_ready   (mrg_ready),
      .lane_sum   (lane_sum),
      .status     (sts_ff[ccr_pkg::NSTAGE-1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---- checks
   a_write_no_slot: assert property (@(posedge clock) disable iff (reset)
      wr_acc |=> !vld_ff[0])
      else $error("write word took a pipeline slot");

   a_few_status: assert property (@(posedge clock) disable iff (reset)
      (eval_acc && (cnt < ccr_pkg::CNT_W'(4))) |=>
      (vld_ff[0] && (sts_ff[0] == ccr_pkg::STATUS_FEW)))
      else $error("too few points not flagged");

   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ccr_pkg::STATUS_FEW)) |-> (rsp_tdata == '0))
      else $error("position not zero with too few points");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ccr_pkg::NSTAGE-1] && !mrg_ready) |=> vld_ff[ccr_pkg::NSTAGE-1])
      else $error("last stage dropped a word under stall");

endmodule
